// ===== rtl/core/sha256_pkg.sv =====
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int unsigned TotalW = 61;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } bk_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] start_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/core/sha256_stream_hasher_unit.sv =====
`timescale 1ns / 1ps
// SHA-256 over a byte stream. Each request carries at most one byte (tuser
// marks it present); tlast ends the message and yields eight digest words,
// H0 first. Bytes pass a 4-deep queue into a compression engine that absorbs
// one byte per cycle while idle; the 64th byte of a block stalls the engine
// for the load, 64 rounds and final add, and a message end adds one or two
// padded blocks and the digest output; the engine takes no byte meanwhile.
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // msg_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_number[34:32]
  output logic        m_axis_tlast    // last_word
);
  import sha256_pkg::*;

  req_t in_req, q_req;
  logic q_valid, q_ready;

  assign in_req = '{data: s_axis_tdata, present: s_axis_tuser, last: s_axis_tlast};

  sha256_fifo u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
    .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
  );

  sha256_engine u_engine (
    .clk(clk), .rst(rst),
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );
endmodule

// ===== rtl/core/sha256_fifo.sv =====
`timescale 1ns / 1ps
module sha256_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sha256_pkg::req_t    in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output sha256_pkg::req_t    out_req
);
  import sha256_pkg::*;

  req_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 3'd4);
  assign out_valid = (count != 3'd0);
  assign out_req   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end
endmodule

// ===== rtl/core/sha256_engine.sv =====
`timescale 1ns / 1ps
module sha256_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  sha256_pkg::req_t req,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast
);
  import sha256_pkg::*;

  bk_state_t          state, state_next;
  logic [31:0]        blk [16];
  logic [31:0]        win [16];
  logic [31:0]        hv [8];
  logic [31:0]        a, b, c, d, e, f, g, h;
  logic [TotalW-1:0]  total;
  logic [5:0]         rnd;
  logic [2:0]         wsel;
  logic               two_blk;
  logic               final_blk;
  logic               finishing;

  logic [5:0]  pos;
  logic [3:0]  idx;
  logic [1:0]  lane;
  logic [31:0] w_new, w_cur, t1, t2, s0, s1;
  logic [63:0] bits;

  assign pos  = total[5:0];
  assign idx  = pos[5:2];
  assign lane = pos[1:0];
  assign bits = {total, 3'b000};

  assign s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
  assign s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
  assign w_new = s1 + win[9] + s0 + win[0];
  assign w_cur = (rnd < 6'd16) ? win[0] : w_new;
  assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + round_k(rnd) + w_cur;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

  assign req_ready     = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tlast  = (wsel == 3'd7);
  assign m_axis_tdata  = {5'b0, wsel, hv[wsel]};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.present && pos == 6'd63) state_next = S_LOAD;
          else if (req.last) state_next = S_PAD;
        end
      end
      S_PAD:   state_next = S_LOAD;
      S_LOAD:  state_next = S_ROUND;
      S_ROUND: if (rnd == 6'd63) state_next = S_ADD;
      S_ADD: begin
        if (finishing && final_blk) state_next = S_OUT;
        else if (finishing) state_next = S_PAD;
        else state_next = S_IDLE;
      end
      S_OUT:   if (m_axis_tready && wsel == 3'd7) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      rnd       <= '0;
      wsel      <= '0;
      two_blk   <= 1'b0;
      final_blk <= 1'b0;
      finishing <= 1'b0;
      for (int i = 0; i < 8; i++) hv[i] <= start_h(3'(i));
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            finishing <= req.last;
            final_blk <= 1'b0;
            two_blk   <= 1'b0;
            if (req.present) begin
              if (lane == 2'd0) blk[idx] <= {req.data, 24'b0};
              else blk[idx] <= blk[idx] | ({24'b0, req.data} << (5'd24 - {lane, 3'b000}));
              total <= total + 1'b1;
            end
          end
        end
        S_PAD: begin
          if (two_blk) begin
            for (int i = 0; i < 14; i++) blk[i] <= '0;
            blk[14]   <= bits[63:32];
            blk[15]   <= bits[31:0];
            final_blk <= 1'b1;
          end else begin
            if (lane == 2'd0) blk[idx] <= 32'h8000_0000;
            else blk[idx] <= (blk[idx] & ~(32'hFFFF_FFFF >> {lane, 3'b000}))
                           | (32'h0000_0080 << (5'd24 - {lane, 3'b000}));
            for (int i = 0; i < 14; i++) begin
              if (4'(i) > idx) blk[i] <= '0;
            end
            if (pos >= 6'd56) begin
              two_blk <= 1'b1;
              if (idx == 4'd14) blk[15] <= '0;
            end else begin
              blk[14]   <= bits[63:32];
              blk[15]   <= bits[31:0];
              final_blk <= 1'b1;
            end
          end
        end
        S_LOAD: begin
          for (int i = 0; i < 16; i++) win[i] <= blk[i];
          {a, b, c, d, e, f, g, h} <= {hv[0], hv[1], hv[2], hv[3],
                                       hv[4], hv[5], hv[6], hv[7]};
          rnd <= '0;
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          win[15] <= w_cur;
          {a, b, c, d, e, f, g, h} <= {t1 + t2, a, b, c, d + t1, e, f, g};
          rnd <= rnd + 6'd1;
        end
        S_ADD: begin
          {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]} <=
            {hv[0] + a, hv[1] + b, hv[2] + c, hv[3] + d,
             hv[4] + e, hv[5] + f, hv[6] + g, hv[7] + h};
          wsel <= '0;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            wsel <= wsel + 3'd1;
            if (wsel == 3'd7) begin
              for (int i = 0; i < 8; i++) hv[i] <= start_h(3'(i));
              total     <= '0;
              finishing <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== verif/sha256_stream_hasher_unit_test.sv =====
`timescale 1ns / 1ps
module sha256_stream_hasher_unit_test;
  import sha256_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        last;
  } digest_t;

  localparam int unsigned IdleLimit = 2000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  req_t    pending_reqs[$];
  digest_t digest_q[$];
  int      errors;
  int      idle_cycles;

  // predictor state
  logic [31:0] hash_h[8];
  logic [31:0] blk[16];
  logic [60:0] nbytes;

  localparam logic [31:0] HashK[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] HashInit[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  sha256_stream_hasher_unit uut (.*);

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int r = 0; r < 64; r++) begin
      if (r < 16) w[r] = blk[r];
      else w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                  + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
    end
    for (int k = 0; k < 8; k++) v[k] = hash_h[k];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + HashK[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) hash_h[k] += v[k];
  endfunction

  function automatic void absorb_byte(req_t rq);
    int pos;
    logic [63:0] bits;
    digest_t d;
    if (rq.present) begin
      pos = nbytes[5:0];
      if (pos % 4 == 0) blk[pos/4] = {rq.data, 24'h0};
      else blk[pos/4] |= 32'(rq.data) << (24 - 8 * (pos % 4));
      nbytes++;
      if (pos == 63) compress();
    end
    if (!rq.last) return;
    pos = nbytes[5:0];
    if (pos % 4 == 0) blk[pos/4] = 32'h8000_0000;
    else blk[pos/4] = (blk[pos/4] & ~(32'hffff_ffff >> (8 * (pos % 4))))
                      | (32'h80 << (24 - 8 * (pos % 4)));
    for (int k = pos/4 + 1; k < 16; k++) blk[k] = '0;
    if (pos >= 56) begin
      compress();
      for (int k = 0; k < 16; k++) blk[k] = '0;
    end
    bits = {nbytes, 3'b000};
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    compress();
    for (int k = 0; k < 8; k++) begin
      d.word = hash_h[k];
      d.num = 3'(k);
      d.last = (k == 7);
      digest_q.push_back(d);
    end
    hash_h = HashInit;
    nbytes = '0;
  endfunction

  task automatic add_msg(int len, bit empty_tail);
    req_t rq;
    for (int i = 0; i < len; i++) begin
      rq.data = 8'($urandom_range(0, 255));
      rq.present = 1'b1;
      rq.last = !empty_tail && (i == len - 1);
      pending_reqs.push_back(rq);
      if ($urandom_range(0, 15) == 0) begin
        rq.present = 1'b0;
        rq.last = 1'b0;
        pending_reqs.push_back(rq);
      end
    end
    if (empty_tail || len == 0) begin
      rq.data = 8'($urandom_range(0, 255));
      rq.present = 1'b0;
      rq.last = 1'b1;
      pending_reqs.push_back(rq);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  int   src_wait;
  logic accepted;

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
  end

  always @(posedge clk) accepted <= !rst && s_axis_tvalid && s_axis_tready;

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_wait <= $urandom_range(0, 9);
    end else if (s_axis_tvalid && !accepted) begin
      s_axis_tvalid <= 1'b1;
    end else if (src_wait > 0) begin
      src_wait <= src_wait - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= pending_reqs[0].data;
      s_axis_tuser <= pending_reqs[0].present;
      s_axis_tlast <= pending_reqs[0].last;
      src_wait <= $urandom_range(0, 9);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      absorb_byte('{data: s_axis_tdata, present: s_axis_tuser, last: s_axis_tlast});
      void'(pending_reqs.pop_front());
    end
  end

  // receiver stalls
  int sink_wait;
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
    end else if (m_axis_tready && m_axis_tvalid) begin
      sink_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_t exp_d;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", m_axis_tdata[31:0]);
          errors++;
        end else begin
          exp_d = digest_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_d.word) begin
            $error("digest_word exp %h got %h", exp_d.word, m_axis_tdata[31:0]);
            errors++;
          end
          if (m_axis_tdata[34:32] !== exp_d.num) begin
            $error("word_number exp %0d got %0d", exp_d.num, m_axis_tdata[34:32]);
            errors++;
          end
          if (m_axis_tlast !== exp_d.last) begin
            $error("last_word exp %0d got %0d", exp_d.last, m_axis_tlast);
            errors++;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int len;
    errors = 0;
    hash_h = HashInit;
    nbytes = '0;
    for (int k = 0; k < 16; k++) blk[k] = '0;
    rst = 1'b1;
    // directed: empty message, byte extremes, padding boundaries
    add_msg(0, 1'b0);
    pending_reqs.push_back('{data: 8'h00, present: 1'b1, last: 1'b1});
    pending_reqs.push_back('{data: 8'hff, present: 1'b1, last: 1'b0});
    pending_reqs.push_back('{data: 8'h00, present: 1'b0, last: 1'b0});
    pending_reqs.push_back('{data: 8'haa, present: 1'b0, last: 1'b1});
    add_msg(3, 1'b0);
    add_msg(4, 1'b1);
    add_msg(5, 1'b0);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // padding corners: 55, 56, 63, 64 bytes
    add_msg(55, 1'b0);
    add_msg(56, 1'b1);
    add_msg(63, 1'b0);
    add_msg(64, 1'b0);
    for (int m = 0; m < 3; m++) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      add_msg(len, $urandom_range(0, 3) == 0);
    end
    while (pending_reqs.size() > 0) @(posedge clk);
    while (digest_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
